FILE: hw/rtl/hgmm_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and control types of the height grid normalizer.
package hgmm_pkg;

  localparam int MAX_SIDE = 256;
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int CELLS = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int USED_W = 2 * SIDE_W;
  localparam int XZC_W = SIDE_W + 8;
  localparam int IDXC_W = USED_W + 16;

  localparam int Q_W = 32;
  localparam int SIDE_REG_W = 9;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W = 6;
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 64;

  localparam logic [2:0] OP_WR_XZ = 3'd0;
  localparam logic [2:0] OP_WR_IDX = 3'd1;
  localparam logic [2:0] OP_RD_XZ = 3'd2;
  localparam logic [2:0] OP_RD_IDX = 3'd3;
  localparam logic [2:0] OP_NORM = 3'd4;
  localparam logic [2:0] OP_QUERY = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FLAT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 2'd2;

  typedef struct packed {
    logic take;
    logic item_wr;
    logic item_rd;
    logic rd_keep;
    logic clr_wr;
    logic ptr_clr;
    logic scan;
    logic norm_rd;
    logic num_load;
    logic mul_step;
    logic div_load;
    logic div_step;
    logic cell_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic inrange;
    logic clr_last;
    logic scan_done;
    logic flat;
    logic ptr_last;
    logic mul_last;
    logic div_last;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/height_grid_min_max_normalize.sv
`timescale 1ns / 1ps
// Height grid with cell access, min/max query and min-max normalize: top level.
// After reset the block clears its 65536-cell grid memory, one cell a cycle, and accepts no
// request until the clear is done. Then it works on one request at a time: a write is
// decoded and written, a read waits for the registered memory read, and a range error or
// unused code goes straight to its result. Min/max query scans the cells in use through the
// single read port. Normalize scans once and, if the grid is not flat, takes each cell
// in use through one read, a 32-step shift-add multiplier and a 64-step restoring divider,
// then the write back. The output register lets the next request in while a result waits.
module height_grid_min_max_normalize import hgmm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [Q_W-1:0]        cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            operation_i,
  input  logic [7:0]            column_i,
  input  logic [7:0]            row_i,
  input  logic [15:0]           cell_index_i,
  input  logic signed [Q_W-1:0] new_height_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [Q_W-1:0] read_height_o,
  output logic signed [Q_W-1:0] lowest_o,
  output logic signed [Q_W-1:0] highest_o,
  output logic [1:0]            status_o
);

  cmd_t cmd;
  sts_t sts;

  hgmm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  hgmm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .operation_i  (operation_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .cell_index_i (cell_index_i),
    .new_height_i (new_height_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_height_o(read_height_o),
    .lowest_o     (lowest_o),
    .highest_o    (highest_o),
    .status_o     (status_o)
  );

endmodule

FILE: hw/rtl/hgmm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with registered read.
module hgmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/hgmm_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the height grid normalizer.
module hgmm_ctrl import hgmm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_DECODE = 13'b0000000000100,
    S_RDWAIT = 13'b0000000001000,
    S_SCAN   = 13'b0000000010000,
    S_NRD    = 13'b0000000100000,
    S_NLOAD  = 13'b0000001000000,
    S_MUL    = 13'b0000010000000,
    S_DIVSET = 13'b0000100000000,
    S_DIV    = 13'b0001000000000,
    S_NWR    = 13'b0010000000000,
    S_DONE   = 13'b0100000000000,
    S_SPARE  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.ptr_clr = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        if ((sts_i.op == OP_WR_XZ || sts_i.op == OP_WR_IDX) && sts_i.inrange) begin
          cmd_o.item_wr = 1'b1;
        end else if ((sts_i.op == OP_RD_XZ || sts_i.op == OP_RD_IDX) && sts_i.inrange) begin
          cmd_o.item_rd = 1'b1;
          state_d = S_RDWAIT;
        end else if (sts_i.op == OP_NORM || sts_i.op == OP_QUERY) begin
          cmd_o.ptr_clr = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_RDWAIT: begin
        cmd_o.rd_keep = 1'b1;
        state_d = S_DONE;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          if (sts_i.op == OP_QUERY || sts_i.flat) begin
            state_d = S_DONE;
          end else begin
            cmd_o.ptr_clr = 1'b1;
            state_d = S_NRD;
          end
        end
      end
      S_NRD: begin
        cmd_o.norm_rd = 1'b1;
        state_d = S_NLOAD;
      end
      S_NLOAD: begin
        cmd_o.num_load = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          state_d = S_DIVSET;
        end
      end
      S_DIVSET: begin
        cmd_o.div_load = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_NWR;
        end
      end
      S_NWR: begin
        cmd_o.cell_wr = 1'b1;
        state_d = sts_i.ptr_last ? S_DONE : S_NRD;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/hgmm_dp.sv
`timescale 1ns / 1ps
// Datapath of the height grid normalizer: registers, grid memory, scan and arithmetic.
module hgmm_dp import hgmm_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cmd_t                    cmd_i,
  output sts_t                    sts_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [Q_W-1:0]          cfg_data_i,
  input  logic [2:0]              operation_i,
  input  logic [7:0]              column_i,
  input  logic [7:0]              row_i,
  input  logic [15:0]             cell_index_i,
  input  logic signed [Q_W-1:0]   new_height_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [Q_W-1:0]   read_height_o,
  output logic signed [Q_W-1:0]   lowest_o,
  output logic signed [Q_W-1:0]   highest_o,
  output logic [1:0]              status_o
);

  logic [SIDE_REG_W-1:0] side_q;
  logic signed [Q_W-1:0] low_q, high_q;

  logic [2:0] op_q;
  logic [ADDR_W-1:0] addr_q;
  logic inrange_q;
  logic [Q_W-1:0] wdata_q;

  logic [CNT_W-1:0] ptr_q;
  logic pend_q, have_q;
  logic signed [Q_W-1:0] mn_q, mx_q;
  logic [Q_W-1:0] rd_q;
  logic [Q_W-1:0] mcand_q;
  logic [2*Q_W-1:0] prod_q;
  logic [Q_W-1:0] rem_q;
  logic [STEP_W-1:0] step_q;

  logic out_valid_q;
  logic [Q_W-1:0] out_rd_q, out_lo_q, out_hi_q;
  logic [1:0] out_st_q;

  logic [SIDE_W-1:0] side_eff;
  logic [USED_W-1:0] used;
  logic [XZC_W-1:0] xz_mul;
  logic [XZC_W:0] xz_addr;
  logic xz_ok, idx_ok, in_ok;
  logic [ADDR_W-1:0] in_addr;
  logic xz_op, idx_op;

  logic [Q_W-1:0] rdata;
  logic scan_issue, mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [Q_W-1:0] mem_wdata;

  logic [Q_W:0] span;
  logic span_neg;
  logic [Q_W-1:0] uspan, den;
  logic [Q_W:0] mul_sum, trial;
  logic div_ge;
  logic signed [2*Q_W+1:0] lo_x, q_x, v_x;
  logic [Q_W-1:0] sat;
  logic flat;
  logic [1:0] st_new;

  always_comb begin
    side_eff = SIDE_W'(side_q);
    if (side_q == '0) begin
      side_eff = SIDE_W'(1);
    end else if (side_q > SIDE_REG_W'(MAX_SIDE)) begin
      side_eff = SIDE_W'(MAX_SIDE);
    end
  end

  assign used = USED_W'(side_eff) * USED_W'(side_eff);
  assign xz_mul = XZC_W'(side_eff) * XZC_W'(row_i);
  assign xz_addr = {1'b0, xz_mul} + (XZC_W + 1)'(column_i);
  assign xz_ok = (XZC_W'(column_i) < XZC_W'(side_eff)) && (XZC_W'(row_i) < XZC_W'(side_eff));
  assign idx_ok = IDXC_W'(cell_index_i) < IDXC_W'(used);
  assign xz_op = (operation_i == OP_WR_XZ) || (operation_i == OP_RD_XZ);
  assign idx_op = (operation_i == OP_WR_IDX) || (operation_i == OP_RD_IDX);
  assign in_ok = xz_op ? xz_ok : (idx_op ? idx_ok : 1'b0);
  assign in_addr = xz_op ? xz_addr[ADDR_W-1:0] : cell_index_i[ADDR_W-1:0];

  assign scan_issue = cmd_i.scan && (USED_W'(ptr_q) < used);

  assign span = {high_q[Q_W-1], high_q} - {low_q[Q_W-1], low_q};
  assign span_neg = span[Q_W];
  assign uspan = span_neg ? Q_W'(-span) : span[Q_W-1:0];
  assign den = Q_W'(mx_q - mn_q);
  assign flat = !(mx_q > mn_q);

  assign mul_sum = {1'b0, prod_q[2*Q_W-1:Q_W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
  assign trial = {rem_q, prod_q[2*Q_W-1]};
  assign div_ge = trial >= {1'b0, den};

  assign lo_x = {{(Q_W+2){low_q[Q_W-1]}}, low_q};
  assign q_x = {2'b00, prod_q};
  assign v_x = span_neg ? (lo_x - q_x) : (lo_x + q_x);

  always_comb begin
    sat = v_x[Q_W-1:0];
    if (v_x > (2*Q_W+2)'(signed'(33'sh0_7FFF_FFFF))) begin
      sat = {1'b0, {(Q_W-1){1'b1}}};
    end else if (v_x < (2*Q_W+2)'(signed'(33'sh1_8000_0000))) begin
      sat = {1'b1, {(Q_W-1){1'b0}}};
    end
  end

  assign mem_we = cmd_i.clr_wr || cmd_i.item_wr || cmd_i.cell_wr;
  assign mem_waddr = cmd_i.item_wr ? addr_q : ptr_q[ADDR_W-1:0];
  assign mem_wdata = cmd_i.clr_wr ? '0 : (cmd_i.item_wr ? wdata_q : sat);
  assign mem_re = cmd_i.item_rd || scan_issue || cmd_i.norm_rd;
  assign mem_raddr = cmd_i.item_rd ? addr_q : ptr_q[ADDR_W-1:0];

  hgmm_ram #(
    .WIDTH(Q_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    st_new = ST_OK;
    if ((op_q == OP_WR_XZ || op_q == OP_WR_IDX || op_q == OP_RD_XZ || op_q == OP_RD_IDX)
        && !inrange_q) begin
      st_new = ST_RANGE;
    end else if (op_q == OP_NORM && flat) begin
      st_new = ST_FLAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SIDE_REG_W'(256);
      low_q <= '0;
      high_q <= Q_W'(65536);
      ptr_q <= '0;
      pend_q <= 1'b0;
      have_q <= 1'b0;
      out_valid_q <= 1'b0;
      step_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SIDE: side_q <= cfg_data_i[SIDE_REG_W-1:0];
          CFG_LOW:  low_q <= cfg_data_i;
          CFG_HIGH: high_q <= cfg_data_i;
          default:  ;
        endcase
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
        have_q <= 1'b0;
      end else if (cmd_i.clr_wr || cmd_i.cell_wr || scan_issue) begin
        ptr_q <= ptr_q + CNT_W'(1);
      end
      pend_q <= scan_issue;
      if (pend_q) begin
        have_q <= 1'b1;
      end
      if (cmd_i.num_load || cmd_i.div_load) begin
        step_q <= '0;
      end else if (cmd_i.mul_step || cmd_i.div_step) begin
        step_q <= step_q + STEP_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q <= operation_i;
      addr_q <= in_addr;
      inrange_q <= in_ok;
      wdata_q <= new_height_i;
    end
    if (cmd_i.rd_keep) begin
      rd_q <= rdata;
    end
    if (pend_q) begin
      if (!have_q || signed'(rdata) < mn_q) begin
        mn_q <= rdata;
      end
      if (!have_q || signed'(rdata) > mx_q) begin
        mx_q <= rdata;
      end
    end
    if (cmd_i.num_load) begin
      mcand_q <= Q_W'(signed'(rdata) - mn_q);
      prod_q <= {{Q_W{1'b0}}, uspan};
    end else if (cmd_i.mul_step) begin
      prod_q <= {mul_sum, prod_q[Q_W-1:1]};
    end else if (cmd_i.div_step) begin
      prod_q <= {prod_q[2*Q_W-2:0], div_ge};
    end
    if (cmd_i.div_load) begin
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? Q_W'(trial - {1'b0, den}) : trial[Q_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_rd_q <= ((op_q == OP_RD_XZ || op_q == OP_RD_IDX) && inrange_q) ? rd_q : '0;
      out_lo_q <= (op_q == OP_QUERY) ? mn_q : '0;
      out_hi_q <= (op_q == OP_QUERY) ? mx_q : '0;
      out_st_q <= st_new;
    end
  end

  assign sts_o.op = op_q;
  assign sts_o.inrange = inrange_q;
  assign sts_o.clr_last = (ptr_q == CNT_W'(CELLS - 1));
  assign sts_o.scan_done = !scan_issue && !pend_q;
  assign sts_o.flat = flat;
  assign sts_o.ptr_last = (USED_W'(ptr_q) == used - USED_W'(1));
  assign sts_o.mul_last = (step_q == STEP_W'(MUL_STEPS - 1));
  assign sts_o.div_last = (step_q == STEP_W'(DIV_STEPS - 1));
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign read_height_o = out_rd_q;
  assign lowest_o = out_lo_q;
  assign highest_o = out_hi_q;
  assign status_o = out_st_q;

endmodule

FILE: test/tb_height_grid_min_max_normalize.sv
`timescale 1ns / 1ps
// Self-checking testbench of the height grid normalizer: random requests under random stalls.
module tb_height_grid_min_max_normalize;
  import hgmm_pkg::*;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam int LIMIT_CYCLES = 4000000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [15:0] idx;
    logic [31:0] hgt;
  } req_t;

  typedef struct {
    logic [31:0] rd;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [1:0]  st;
  } rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [Q_W-1:0] cfg_data_i = '0;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [2:0] operation_i;
  logic [7:0] column_i, row_i;
  logic [15:0] cell_index_i;
  logic signed [Q_W-1:0] new_height_i, read_height_o, lowest_o, highest_o;
  logic [1:0] status_o;

  height_grid_min_max_normalize u_top (.*);

  always #5 clk_i = ~clk_i;

  int grid_mem [CELLS];
  logic [8:0] side_reg;
  int tgt_low, tgt_high;
  req_t req_q[$];
  rsp_t grid_rsp_q[$];
  bit idle_on = 1'b1;
  int fail_cnt = 0, rsp_cnt = 0, norm_cnt = 0, flat_cnt = 0, range_cnt = 0;
  int cycle_cnt = 0;

  function automatic int eff_side();
    if (side_reg == 0) return 1;
    if (side_reg > MAX_SIDE) return MAX_SIDE;
    return side_reg;
  endfunction

  function automatic void grid_extremes(input int used, output int mn, output int mx);
    mn = grid_mem[0];
    mx = grid_mem[0];
    for (int i = 1; i < used; i++) begin
      if (grid_mem[i] < mn) mn = grid_mem[i];
      if (grid_mem[i] > mx) mx = grid_mem[i];
    end
  endfunction

  function automatic logic [1:0] normalize_grid(input int used);
    int mn, mx;
    longint lo, span, v;
    longint unsigned uspan, den, num, q;
    lo = tgt_low;
    span = longint'(tgt_high) - lo;
    uspan = (span < 0) ? -span : span;
    grid_extremes(used, mn, mx);
    if (mx <= mn) return ST_FLAT;
    den = longint'(mx) - longint'(mn);
    for (int i = 0; i < used; i++) begin
      num = longint'(grid_mem[i]) - longint'(mn);
      q = (num * uspan) / den;
      v = (span < 0) ? lo - longint'(q) : lo + longint'(q);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      grid_mem[i] = int'(v);
    end
    return ST_OK;
  endfunction

  function automatic rsp_t grid_apply(input req_t r);
    rsp_t e;
    int side, used, mn, mx;
    int addr;
    bit ok;
    side = eff_side();
    used = side * side;
    e = '{rd: '0, lo: '0, hi: '0, st: ST_OK};
    ok = 1'b0;
    addr = 0;
    if (r.op == OP_WR_XZ || r.op == OP_RD_XZ) begin
      ok = (r.col < side) && (r.row < side);
      addr = r.col + side * r.row;
    end else if (r.op == OP_WR_IDX || r.op == OP_RD_IDX) begin
      ok = r.idx < used;
      addr = r.idx;
    end
    if (r.op <= OP_RD_IDX) begin
      if (!ok) e.st = ST_RANGE;
      else if (r.op <= OP_WR_IDX) grid_mem[addr] = r.hgt;
      else e.rd = grid_mem[addr];
    end else if (r.op == OP_NORM) begin
      e.st = normalize_grid(used);
    end else if (r.op == OP_QUERY) begin
      grid_extremes(used, mn, mx);
      e.lo = mn;
      e.hi = mx;
    end
    return e;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      operation_i <= '0;
      column_i <= '0;
      row_i <= '0;
      cell_index_i <= '0;
      new_height_i <= '0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) begin
        grid_rsp_q.push_back(grid_apply('{operation_i, column_i, row_i, cell_index_i,
                                          new_height_i}));
      end
      if (req_q.size() > 0 && !(idle_on && $urandom_range(99) < 29)) begin
        req_t r;
        r = req_q.pop_front();
        in_valid_i <= 1'b1;
        operation_i <= r.op;
        column_i <= r.col;
        row_i <= r.row;
        cell_index_i <= r.idx;
        new_height_i <= r.hgt;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= idle_on && ($urandom_range(99) < 29);
      if (out_valid_o && !out_stall_i) begin
        rsp_t e;
        if (grid_rsp_q.size() == 0) begin
          $display("%0t: unexpected result rd=%h lo=%h hi=%h st=%0d", $time,
                   read_height_o, lowest_o, highest_o, status_o);
          fail_cnt++;
        end else begin
          e = grid_rsp_q.pop_front();
          rsp_cnt++;
          if (e.st == ST_RANGE) range_cnt++;
          if (e.st == ST_FLAT) flat_cnt++;
          if (read_height_o !== e.rd || lowest_o !== e.lo || highest_o !== e.hi ||
              status_o !== e.st) begin
            $display("%0t: mismatch expected rd=%h lo=%h hi=%h st=%0d actual rd=%h lo=%h hi=%h st=%0d",
                     $time, e.rd, e.lo, e.hi, e.st, read_height_o, lowest_o, highest_o,
                     status_o);
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic add_req(input logic [2:0] op, input int col, input int row, input int idx,
                         input logic [31:0] hgt);
    req_q.push_back('{op, col[7:0], row[7:0], idx[15:0], hgt});
    if (op == OP_NORM) norm_cnt++;
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (req_q.size() != 0 || in_valid_i || grid_rsp_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input int side, input int low, input int high);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_SIDE;
    cfg_data_i <= side;
    @(posedge clk_i);
    cfg_idx_i <= CFG_LOW;
    cfg_data_i <= low;
    @(posedge clk_i);
    cfg_idx_i <= CFG_HIGH;
    cfg_data_i <= high;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    side_reg = side[8:0];
    tgt_low = low;
    tgt_high = high;
  endtask

  function automatic logic [31:0] rand_height();
    int k;
    k = $urandom_range(7);
    if (k == 0) return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
    if (k < 4) return $urandom_range(200000) - 100000;
    return $urandom;
  endfunction

  task automatic fill_random(input int count);
    int side, k;
    logic [2:0] op;
    side = eff_side();
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99);
      if (k < 35) op = $urandom_range(1) ? OP_WR_XZ : OP_WR_IDX;
      else if (k < 75) op = $urandom_range(1) ? OP_RD_XZ : OP_RD_IDX;
      else if (k < 82 && side <= 8) op = OP_NORM;
      else if (k < 92 && side <= 16) op = OP_QUERY;
      else if (k < 96) op = $urandom_range(1) ? OP_SPARE_A : OP_SPARE_B;
      else op = OP_WR_XZ;
      if ($urandom_range(9) == 0)
        add_req(op, $urandom_range(255), $urandom_range(255), $urandom_range(65535), $urandom);
      else
        add_req(op, $urandom_range(side - 1), $urandom_range(side - 1),
                $urandom_range(side * side - 1), rand_height());
    end
  endtask

  typedef struct {
    int side;
    int low;
    int high;
  } setting_t;

  setting_t settings[] = '{
    '{0, 32'sh8000_0000, 32'sh7fff_ffff}, '{1, -65536, 65536},
    '{2, 32'sh7fff_ffff, 32'sh8000_0000}, '{3, -65536, 65536},
    '{5, 65536, 0}, '{8, 0, 65536}, '{8, -100, 7},
    '{16, 123456, -98765}, '{300, 0, 65536}, '{4, 0, 65536}
  };

  initial begin
    for (int i = 0; i < CELLS; i++) grid_mem[i] = 0;
    side_reg = 9'd256;
    tgt_low = 0;
    tgt_high = 65536;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_req(OP_WR_XZ, 255, 255, 0, 32'h7fff_ffff);
    add_req(OP_WR_IDX, 0, 0, 0, 32'h8000_0000);
    add_req(OP_WR_IDX, 0, 0, 65534, 32'hffff_ffff);
    add_req(OP_RD_XZ, 255, 255, 0, 32'h0);
    add_req(OP_RD_IDX, 0, 0, 0, 32'h0);
    add_req(OP_RD_IDX, 0, 0, 65534, 32'h0);
    add_req(OP_RD_XZ, 0, 0, 0, 32'h0);
    add_req(OP_SPARE_A, 255, 255, 65535, 32'hffff_ffff);
    add_req(OP_SPARE_B, 0, 0, 0, 32'h0);
    add_req(OP_QUERY, 0, 0, 0, 32'h0);
    wait_idle();

    write_cfg(0, 32'sh8000_0000, 32'sh7fff_ffff);
    add_req(OP_WR_XZ, 1, 0, 0, 32'h1234);
    add_req(OP_RD_XZ, 0, 1, 0, 32'h0);
    add_req(OP_WR_IDX, 0, 0, 1, 32'h1234);
    add_req(OP_NORM, 0, 0, 0, 32'h0);
    add_req(OP_QUERY, 0, 0, 0, 32'h0);
    wait_idle();

    write_cfg(4, 32'sh8000_0000, 32'sh7fff_ffff);
    add_req(OP_WR_XZ, 3, 3, 0, 32'h7fff_ffff);
    add_req(OP_WR_IDX, 0, 0, 5, 32'h8000_0000);
    add_req(OP_NORM, 0, 0, 0, 32'h0);
    add_req(OP_QUERY, 0, 0, 0, 32'h0);
    add_req(OP_RD_IDX, 0, 0, 15, 32'h0);
    add_req(OP_RD_IDX, 0, 0, 5, 32'h0);
    add_req(OP_RD_IDX, 0, 0, 16, 32'h0);
    wait_idle();

    foreach (settings[i]) begin
      write_cfg(settings[i].side, settings[i].low, settings[i].high);
      idle_on = (i != 5);
      fill_random(128);
      wait_idle();
    end

    $display("Covered %0d results: %0d normalize requests, %0d flat grids, %0d range errors,",
             rsp_cnt, norm_cnt, flat_cnt, range_cnt);
    $display("over %0d grid settings from side 1 to the full grid.", settings.size() + 3);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
